@@ rtl/core/wpp_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// wpp_pkg
// Shared types, register indexes and the quaternion-to-matrix function.
// -----------------------------------------------------------------------------
package wpp_pkg;

	// pipeline depth: input stage 1 to output register
	localparam int NUM_STAGES = 35;
	// quotient bits resolved by the dividers, one per stage
	localparam int DIV_BITS   = 26;

	// configuration register indexes
	localparam logic [2:0] REG_FOCAL_X = 3'd0;
	localparam logic [2:0] REG_FOCAL_Y = 3'd1;
	localparam logic [2:0] REG_CENTER_X = 3'd2;
	localparam logic [2:0] REG_CENTER_Y = 3'd3;
	localparam logic [2:0] REG_EXT_QUAT = 3'd4;
	localparam logic [2:0] REG_EXT_TX = 3'd5;
	localparam logic [2:0] REG_EXT_TY = 3'd6;
	localparam logic [2:0] REG_EXT_TZ = 3'd7;

	localparam logic [63:0] EXT_QUAT_RESET = 64'h4000_0000_0000_0000;

	localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;
	localparam logic signed [34:0] HALF_Q12 = 35'sd2048;

	typedef logic signed [21:0] mat_elem_t;
	typedef mat_elem_t mat_t [0:8];
	typedef logic signed [39:0] body_t;
	typedef logic signed [31:0] coord_t;

	typedef struct packed {
		logic neg;
		logic ovf;
	} div_flag_t;

	// Row-major rotation matrix in Q16 from a Q2.14 quaternion, round half up.
	function automatic mat_t quat_mat(input logic signed [15:0] w, input logic signed [15:0] x,
		input logic signed [15:0] y, input logic signed [15:0] z);
		logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
		logic signed [34:0] r [0:8];
		mat_t m;
		xx = x * x;
		yy = y * y;
		zz = z * z;
		xy = x * y;
		xz = x * z;
		yz = y * z;
		wx = w * x;
		wy = w * y;
		wz = w * z;
		r[0] = ONE_Q28 - ((35'(yy) + 35'(zz)) <<< 1);
		r[1] = (35'(xy) - 35'(wz)) <<< 1;
		r[2] = (35'(xz) + 35'(wy)) <<< 1;
		r[3] = (35'(xy) + 35'(wz)) <<< 1;
		r[4] = ONE_Q28 - ((35'(xx) + 35'(zz)) <<< 1);
		r[5] = (35'(yz) - 35'(wx)) <<< 1;
		r[6] = (35'(xz) - 35'(wy)) <<< 1;
		r[7] = (35'(yz) + 35'(wx)) <<< 1;
		r[8] = ONE_Q28 - ((35'(xx) + 35'(yy)) <<< 1);
		for (int i = 0; i < 9; i++) begin
			m[i] = 22'((r[i] + HALF_Q12) >>> 12);
		end
		return m;
	endfunction

endpackage

@@ rtl/core/wpp_body_xform.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// wpp_body_xform
// Stages 1-3: world point into the body frame, R(q)^T * (p - t).
// -----------------------------------------------------------------------------
module wpp_body_xform (
	input  logic                 clk,
	input  logic [2:0]           ld,
	input  logic signed [31:0]   point_x,
	input  logic signed [31:0]   point_y,
	input  logic signed [31:0]   point_z,
	input  logic signed [15:0]   pose_qw,
	input  logic signed [15:0]   pose_qx,
	input  logic signed [15:0]   pose_qy,
	input  logic signed [15:0]   pose_qz,
	input  logic signed [31:0]   pose_tx,
	input  logic signed [31:0]   pose_ty,
	input  logic signed [31:0]   pose_tz,
	output wpp_pkg::body_t       pb_s3 [0:2]
);

	wpp_pkg::mat_t           rp_s1;
	logic signed [32:0]      d_s1 [0:2];
	logic signed [54:0]      pr_s2 [0:2][0:2];
	logic signed [56:0]      acc [0:2];
	logic signed [56:0]      rnd [0:2];

	// stage 1: pose matrix and exact difference
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			rp_s1   <= wpp_pkg::quat_mat(pose_qw, pose_qx, pose_qy, pose_qz);
			d_s1[0] <= 33'(point_x) - 33'(pose_tx);
			d_s1[1] <= 33'(point_y) - 33'(pose_ty);
			d_s1[2] <= 33'(point_z) - 33'(pose_tz);
		end
	end

	// stage 2: transposed matrix products
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					pr_s2[i][k] <= rp_s1[3 * k + i] * d_s1[k];
				end
			end
		end
	end

	// stage 3: row sums, round to Q24.16
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = 57'(pr_s2[i][0]) + 57'(pr_s2[i][1]) + 57'(pr_s2[i][2]) + 57'sd32768;
			rnd[i] = acc[i] >>> 16;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			for (int i = 0; i < 3; i++) begin
				pb_s3[i] <= rnd[i][39:0];
			end
		end
	end

endmodule

@@ rtl/core/wpp_cam_xform.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// wpp_cam_xform
// Stages 4-6: body point into the camera frame, Re * pb + te, saturated.
// -----------------------------------------------------------------------------
module wpp_cam_xform (
	input  logic                 clk,
	input  logic [2:0]           ld,
	input  logic [63:0]          ext_quat,
	input  wpp_pkg::coord_t      ext_t [0:2],
	input  wpp_pkg::body_t       pb_s3 [0:2],
	output wpp_pkg::coord_t      cam_s6 [0:2],
	output logic                 sat_s6
);

	wpp_pkg::mat_t           re_q;
	logic signed [42:0]      pl_s4 [0:2][0:2];
	logic signed [41:0]      ph_s4 [0:2][0:2];
	logic signed [62:0]      sm_s5 [0:2];
	logic signed [62:0]      rnd [0:2];
	logic signed [62:0]      tot [0:2];
	wpp_pkg::coord_t         cam [0:2];
	logic [2:0]              ov;

	// extrinsic matrix follows the register, ready long before an item needs it
	always_ff @(posedge clk) begin
		re_q <= wpp_pkg::quat_mat($signed(ext_quat[63:48]), $signed(ext_quat[47:32]),
			$signed(ext_quat[31:16]), $signed(ext_quat[15:0]));
	end

	// stage 4: split the body point into two halves to keep multipliers narrow
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					pl_s4[i][k] <= re_q[3 * i + k] * $signed({1'b0, pb_s3[k][19:0]});
					ph_s4[i][k] <= re_q[3 * i + k] * $signed(pb_s3[k][39:20]);
				end
			end
		end
	end

	// stage 5: recombine halves and sum the row
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			for (int i = 0; i < 3; i++) begin
				sm_s5[i] <= (63'(ph_s4[i][0]) <<< 20) + 63'(pl_s4[i][0])
					+ (63'(ph_s4[i][1]) <<< 20) + 63'(pl_s4[i][1])
					+ (63'(ph_s4[i][2]) <<< 20) + 63'(pl_s4[i][2]);
			end
		end
	end

	// stage 6: round, add translation, clamp to 32 bits
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = (sm_s5[i] + 63'sd32768) >>> 16;
			tot[i] = rnd[i] + 63'(ext_t[i]);
			ov[i]  = 1'b0;
			if (tot[i] > 63'sd2147483647) begin
				cam[i] = 32'sh7FFF_FFFF;
				ov[i]  = 1'b1;
			end else if (tot[i] < -63'sd2147483648) begin
				cam[i] = 32'sh8000_0000;
				ov[i]  = 1'b1;
			end else begin
				cam[i] = tot[i][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			for (int i = 0; i < 3; i++) begin
				cam_s6[i] <= cam[i];
			end
			sat_s6 <= |ov;
		end
	end

endmodule

@@ rtl/core/wpp_divider.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// wpp_divider
// Pipelined restoring divider: |num| / den, one quotient bit per stage.
// -----------------------------------------------------------------------------
module wpp_divider (
	input  logic                          clk,
	input  logic [wpp_pkg::DIV_BITS:0]    ld,
	input  logic signed [56:0]            num,
	input  logic signed [31:0]            den,
	output logic [wpp_pkg::DIV_BITS-1:0]  quo,
	output wpp_pkg::div_flag_t            flg
);

	localparam int NB = wpp_pkg::DIV_BITS;

	logic [31:0]          rem_s [0:NB];
	logic [NB-1:0]        wk_s [0:NB];
	logic [31:0]          den_s [0:NB];
	wpp_pkg::div_flag_t   flg_s [0:NB];
	logic signed [56:0]   ab;
	logic [55:0]          mag;

	// entry stage: magnitude, overflow test against den * 2^NB
	always_comb begin
		ab  = num[56] ? -num : num;
		mag = ab[55:0];
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			rem_s[0]     <= 32'(mag[55:NB]);
			wk_s[0]      <= mag[NB-1:0];
			den_s[0]     <= den;
			flg_s[0].neg <= num[56];
			flg_s[0].ovf <= 58'(mag) >= {den, NB'(0)};
		end
	end

	for (genvar j = 1; j <= NB; j++) begin : g_step
		logic [32:0] pre;
		logic [32:0] dif;
		logic        qb;

		always_comb begin
			pre = {rem_s[j-1], wk_s[j-1][NB-1]};
			dif = pre - 33'(den_s[j-1]);
			qb  = pre >= 33'(den_s[j-1]);
		end

		always_ff @(posedge clk) begin
			if (ld[j]) begin
				rem_s[j] <= qb ? dif[31:0] : pre[31:0];
				wk_s[j]  <= {wk_s[j-1][NB-2:0], qb};
				den_s[j] <= den_s[j-1];
				flg_s[j] <= flg_s[j-1];
			end
		end
	end

	assign quo = wk_s[NB];
	assign flg = flg_s[NB];

endmodule

@@ rtl/core/world_point_pinhole_projection.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// world_point_pinhole_projection
// World point to pixel through the inverse body pose, the body-to-camera
// extrinsic and the pinhole intrinsics, fully pipelined.
// -----------------------------------------------------------------------------
// Throughput: one word per cycle while the output is not stalled; the 26
// one-bit divider stages set the depth.
// Each stage holds only when it is full and the stage after it cannot take
// its word, so bubbles close up while a result waits at the output.
// Reset clears every stage valid bit and loads the register reset values
// (identity extrinsic, everything else zero).
module world_point_pinhole_projection (
	input  logic          clk,
	input  logic          arst_n,
	// point_x, point_y, point_z, pose_qw, pose_qx, pose_qy, pose_qz,
	// pose_tx, pose_ty, pose_tz
	input  logic [255:0]  s_tdata,
	input  logic          s_tvalid,
	output logic          s_tready,
	// pixel_u, pixel_v
	output logic [47:0]   m_tdata,
	// valid_res
	output logic          m_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_addr,
	input  logic [63:0]   cfg_wdata
);

	localparam int NS = wpp_pkg::NUM_STAGES;
	localparam int NB = wpp_pkg::DIV_BITS;

	typedef struct packed {
		logic [23:0] pix;
		logic        sat;
	} pix_res_t;

	// configuration
	logic [23:0]        focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [63:0]        ext_quat_q;
	wpp_pkg::coord_t    ext_t_q [0:2];

	// pipeline control
	logic [NS:1]        vld_s;
	logic [NS:1]        ld;

	wpp_pkg::body_t     pb_s3 [0:2];
	wpp_pkg::coord_t    cam_s6 [0:2];
	logic               sat_s6;

	logic signed [56:0] numx_s7, numy_s7;
	logic signed [31:0] z_s7;
	logic               flg_s7, zpos_s7;
	logic [1:0]         fz_s [8:NS-1];

	logic [NB-1:0]      quo_x, quo_y;
	wpp_pkg::div_flag_t dfl_x, dfl_y;
	pix_res_t           res_u, res_v;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= '0;
			focal_y_q  <= '0;
			center_x_q <= '0;
			center_y_q <= '0;
			ext_quat_q <= wpp_pkg::EXT_QUAT_RESET;
			ext_t_q[0] <= '0;
			ext_t_q[1] <= '0;
			ext_t_q[2] <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				wpp_pkg::REG_FOCAL_X:  focal_x_q  <= cfg_wdata[23:0];
				wpp_pkg::REG_FOCAL_Y:  focal_y_q  <= cfg_wdata[23:0];
				wpp_pkg::REG_CENTER_X: center_x_q <= cfg_wdata[23:0];
				wpp_pkg::REG_CENTER_Y: center_y_q <= cfg_wdata[23:0];
				wpp_pkg::REG_EXT_QUAT: ext_quat_q <= cfg_wdata;
				wpp_pkg::REG_EXT_TX:   ext_t_q[0] <= cfg_wdata[31:0];
				wpp_pkg::REG_EXT_TY:   ext_t_q[1] <= cfg_wdata[31:0];
				wpp_pkg::REG_EXT_TZ:   ext_t_q[2] <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or its word moves on; walk back from
	// the output register.
	always_comb begin
		ld[NS] = !vld_s[NS] || m_tready;
		for (int k = NS - 1; k >= 1; k--) begin
			ld[k] = !vld_s[k] || ld[k+1];
		end
	end

	assign s_tready = ld[1];

	// advance valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ld[1]) begin
				vld_s[1] <= s_tvalid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (ld[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// stages 1-3: into the body frame
	wpp_body_xform u_body (
		.clk     (clk),
		.ld      (ld[3:1]),
		.point_x ($signed(s_tdata[31:0])),
		.point_y ($signed(s_tdata[63:32])),
		.point_z ($signed(s_tdata[95:64])),
		.pose_qw ($signed(s_tdata[111:96])),
		.pose_qx ($signed(s_tdata[127:112])),
		.pose_qy ($signed(s_tdata[143:128])),
		.pose_qz ($signed(s_tdata[159:144])),
		.pose_tx ($signed(s_tdata[191:160])),
		.pose_ty ($signed(s_tdata[223:192])),
		.pose_tz ($signed(s_tdata[255:224])),
		.pb_s3   (pb_s3)
	);

	// stages 4-6: into the camera frame
	wpp_cam_xform u_cam (
		.clk      (clk),
		.ld       (ld[6:4]),
		.ext_quat (ext_quat_q),
		.ext_t    (ext_t_q),
		.pb_s3    (pb_s3),
		.cam_s6   (cam_s6),
		.sat_s6   (sat_s6)
	);

	// stage 7: scale by focal length (exact Q24), check depth sign
	always_ff @(posedge clk) begin
		if (ld[7]) begin
			numx_s7 <= $signed({1'b0, focal_x_q}) * cam_s6[0];
			numy_s7 <= $signed({1'b0, focal_y_q}) * cam_s6[1];
			z_s7    <= cam_s6[2];
			zpos_s7 <= cam_s6[2] > 32'sd0;
			flg_s7  <= sat_s6 || !(cam_s6[2] > 32'sd0);
		end
	end

	// carry the depth and saturation flags past the dividers
	always_ff @(posedge clk) begin
		if (ld[8]) begin
			fz_s[8] <= {zpos_s7, flg_s7};
		end
		for (int k = 9; k <= NS - 1; k++) begin
			if (ld[k]) begin
				fz_s[k] <= fz_s[k-1];
			end
		end
	end

	// stages 8-34: divide by depth, truncating toward zero
	wpp_divider u_div_x (
		.clk (clk),
		.ld  (ld[NS-1:8]),
		.num (numx_s7),
		.den (z_s7),
		.quo (quo_x),
		.flg (dfl_x)
	);

	wpp_divider u_div_y (
		.clk (clk),
		.ld  (ld[NS-1:8]),
		.num (numy_s7),
		.den (z_s7),
		.quo (quo_y),
		.flg (dfl_y)
	);

	// Apply sign, add the principal point and clamp to 24 bits. A quotient
	// that overflowed the divider lies far outside the pixel range.
	function automatic pix_res_t pix_fn(input logic [NB-1:0] q, input wpp_pkg::div_flag_t f,
		input logic [23:0] ctr);
		logic signed [27:0] qs;
		logic signed [27:0] sm;
		pix_res_t r;
		qs = f.neg ? -28'({2'b00, q}) : 28'({2'b00, q});
		sm = qs + 28'({4'h0, ctr});
		r.sat = 1'b1;
		if (f.ovf) begin
			r.pix = f.neg ? 24'h80_0000 : 24'h7F_FFFF;
		end else if (sm > 28'sd8388607) begin
			r.pix = 24'h7F_FFFF;
		end else if (sm < -28'sd8388608) begin
			r.pix = 24'h80_0000;
		end else begin
			r.pix = sm[23:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	always_comb begin
		res_u = pix_fn(quo_x, dfl_x, center_x_q);
		res_v = pix_fn(quo_y, dfl_y, center_y_q);
	end

	// stage 35: output register; zero the pixel when depth is not positive
	always_ff @(posedge clk) begin
		if (ld[NS]) begin
			if (fz_s[NS-1][1]) begin
				m_tdata <= {res_v.pix, res_u.pix};
				m_tuser <= !(fz_s[NS-1][0] || res_u.sat || res_v.sat);
			end else begin
				m_tdata <= '0;
				m_tuser <= 1'b0;
			end
		end
	end

	assign m_tvalid = vld_s[NS];

endmodule

@@ test/world_point_pinhole_projection_test.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// world_point_pinhole_projection_test
// Self-checking bench: streams world points with body poses through the
// projection pipeline under several camera setups, predicts each pixel word
// in fixed point and compares it field by field, with random stalls on both
// sides.
// -----------------------------------------------------------------------------
module world_point_pinhole_projection_test;

	// one input word, point_x in the lowest bits
	typedef struct packed {
		logic signed [31:0] pose_tz;
		logic signed [31:0] pose_ty;
		logic signed [31:0] pose_tx;
		logic signed [15:0] pose_qz;
		logic signed [15:0] pose_qy;
		logic signed [15:0] pose_qx;
		logic signed [15:0] pose_qw;
		logic signed [31:0] point_z;
		logic signed [31:0] point_y;
		logic signed [31:0] point_x;
	} point_word_t;

	typedef struct {
		logic signed [23:0] u;
		logic signed [23:0] v;
		logic               ok;
	} pixel_t;

	// Projection predictor and the queue of pixels still owed by the block.
	class pixel_scoreboard;
		logic [63:0] cam_reg [0:7];
		pixel_t      owed [$];
		int          errors;
		int          n_valid;
		int          n_invalid;

		function new();
			foreach (cam_reg[i]) cam_reg[i] = '0;
			cam_reg[wpp_pkg::REG_EXT_QUAT] = wpp_pkg::EXT_QUAT_RESET;
		endfunction

		function void set_reg(logic [2:0] idx, logic [63:0] val);
			cam_reg[idx] = (idx == wpp_pkg::REG_EXT_QUAT) ? val :
				(val & ((idx < wpp_pkg::REG_EXT_QUAT) ? 64'hFF_FFFF : 64'hFFFF_FFFF));
		endfunction

		// round half up, dropping k fraction bits (k = 12 takes Q28 down to Q16)
		static function longint rnd(longint v, int k);
			return (v + (longint'(1) << (k - 1))) >>> k;
		endfunction

		static function void rot(longint w, longint x, longint y, longint z,
			output longint m [0:8]);
			longint one;
			one = longint'(1) << 28;
			m[0] = rnd(one - 2 * (y * y + z * z), 12);
			m[1] = rnd(2 * (x * y - w * z), 12);
			m[2] = rnd(2 * (x * z + w * y), 12);
			m[3] = rnd(2 * (x * y + w * z), 12);
			m[4] = rnd(one - 2 * (x * x + z * z), 12);
			m[5] = rnd(2 * (y * z - w * x), 12);
			m[6] = rnd(2 * (x * z - w * y), 12);
			m[7] = rnd(2 * (y * z + w * x), 12);
			m[8] = rnd(one - 2 * (x * x + y * y), 12);
		endfunction

		static function longint clip(longint v, longint lo, longint hi, ref bit sat);
			if (v < lo) begin
				sat = 1;
				return lo;
			end
			if (v > hi) begin
				sat = 1;
				return hi;
			end
			return v;
		endfunction

		function void note_point(point_word_t p);
			longint d [0:2], pb [0:2], pc [0:2], rp [0:8], re [0:8], s, q;
			logic [63:0] eq;
			bit sat;
			pixel_t r;
			sat = 0;
			eq = cam_reg[wpp_pkg::REG_EXT_QUAT];
			d[0] = longint'(p.point_x) - longint'(p.pose_tx);
			d[1] = longint'(p.point_y) - longint'(p.pose_ty);
			d[2] = longint'(p.point_z) - longint'(p.pose_tz);
			rot(p.pose_qw, p.pose_qx, p.pose_qy, p.pose_qz, rp);
			rot(longint'($signed(eq[63:48])), longint'($signed(eq[47:32])),
				longint'($signed(eq[31:16])), longint'($signed(eq[15:0])), re);
			// inverse pose: transpose of the body rotation
			for (int i = 0; i < 3; i++)
				pb[i] = rnd(rp[i] * d[0] + rp[3 + i] * d[1] + rp[6 + i] * d[2], 16);
			for (int i = 0; i < 3; i++) begin
				s = rnd(re[3 * i] * pb[0] + re[3 * i + 1] * pb[1] + re[3 * i + 2] * pb[2], 16);
				pc[i] = clip(s + longint'($signed(cam_reg[wpp_pkg::REG_EXT_TX + i][31:0])),
					-64'sd2147483648, 64'sd2147483647, sat);
			end
			r.u = '0;
			r.v = '0;
			if (pc[2] > 0) begin
				q = longint'(cam_reg[wpp_pkg::REG_FOCAL_X][23:0]) * pc[0] / pc[2];
				r.u = 24'(clip(q + longint'(cam_reg[wpp_pkg::REG_CENTER_X][23:0]),
					-64'sd8388608, 64'sd8388607, sat));
				q = longint'(cam_reg[wpp_pkg::REG_FOCAL_Y][23:0]) * pc[1] / pc[2];
				r.v = 24'(clip(q + longint'(cam_reg[wpp_pkg::REG_CENTER_Y][23:0]),
					-64'sd8388608, 64'sd8388607, sat));
			end else begin
				sat = 1;
			end
			r.ok = !sat;
			owed.push_back(r);
		endfunction

		function void check_pixel(logic [47:0] data, logic ok);
			pixel_t e;
			if (owed.size() == 0) begin
				$display("%0t: unexpected pixel word u=%h v=%h valid=%b", $time,
					data[23:0], data[47:24], ok);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (e.ok) n_valid++;
			else n_invalid++;
			if (data[23:0] !== e.u) begin
				$display("%0t: pixel_u expected %h actual %h", $time, e.u, data[23:0]);
				errors++;
			end
			if (data[47:24] !== e.v) begin
				$display("%0t: pixel_v expected %h actual %h", $time, e.v, data[47:24]);
				errors++;
			end
			if (ok !== e.ok) begin
				$display("%0t: valid_res expected %b actual %b", $time, e.ok, ok);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic [255:0] s_tdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [47:0]  m_tdata;
	logic         m_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic         cfg_we;
	logic [2:0]   cfg_addr;
	logic [63:0]  cfg_wdata;

	pixel_scoreboard sb;
	int  hold_req;       // set by the main flow to ask for a long output hold-off
	bit  no_idle;        // run both sides without gaps
	int  words_sent;

	world_point_pinhole_projection dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// note every accepted input word, check every accepted output word
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) sb.note_point(s_tdata);
		if (arst_n && m_tvalid && m_tready) sb.check_pixel(m_tdata, m_tuser);
	end

	// receiver: random back-pressure, plus a long hold-off on request
	initial begin
		int stall;
		stall = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				stall = hold_req;
				hold_req = 0;
			end else if (stall == 0) begin
				stall = gap_len();
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// present one word and hold it until accepted, then maybe idle
	task automatic send_point(point_word_t p);
		int g;
		s_tdata <= p;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// lower valid and wait until the pipeline has drained
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() > 0) @(posedge clk);
		repeat (wpp_pkg::NUM_STAGES + 5) @(posedge clk);
	endtask

	// write all eight camera registers back to back while the block is idle
	task automatic load_camera(logic [63:0] v [0:7]);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= 3'(i);
			cfg_wdata <= v[i];
			sb.set_reg(3'(i), v[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// fully random bits in every field
	function automatic point_word_t noise_point();
		return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	// near-unit pose, point a few metres from the body
	function automatic point_word_t sane_point();
		point_word_t p;
		real a, b, c, d, n;
		a = $urandom_range(0, 2000) - 1000.0;
		b = $urandom_range(0, 2000) - 1000.0;
		c = $urandom_range(0, 2000) - 1000.0;
		d = $urandom_range(0, 2000) - 1000.0;
		n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
		p.pose_qw = 16'($rtoi(16384.0 * a / n));
		p.pose_qx = 16'($rtoi(16384.0 * b / n));
		p.pose_qy = 16'($rtoi(16384.0 * c / n));
		p.pose_qz = 16'($rtoi(16384.0 * d / n));
		p.pose_tx = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
		p.pose_ty = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
		p.pose_tz = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
		p.point_x = p.pose_tx + $signed($urandom_range(0, 32'h0014_0000)) - 32'sh000A_0000;
		p.point_y = p.pose_ty + $signed($urandom_range(0, 32'h0014_0000)) - 32'sh000A_0000;
		p.point_z = p.pose_tz + $signed($urandom_range(0, 32'h0014_0000)) - 32'sh000A_0000;
		return p;
	endfunction

	function automatic point_word_t make_point(int px, int py, int pz, int qw,
		int qx, int qy, int qz, int tx, int ty, int tz);
		return {tz, ty, tx, 16'(qz), 16'(qy), 16'(qx), 16'(qw), pz, py, px};
	endfunction

	initial begin
		logic [63:0] cam [0:7];
		int r;
		sb = new();
		hold_req = 0;
		no_idle = 0;
		words_sent = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = wpp_pkg::REG_FOCAL_X;
		cfg_wdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setup: zero focal length, identity extrinsic
		send_point(make_point(0, 0, 32'h0001_0000, 16'h4000, 0, 0, 0, 0, 0, 0));
		send_point(make_point(0, 0, 0, 16'h4000, 0, 0, 0, 0, 0, 0));
		drain();

		// typical camera: 500 px focal, 640x480 centre, small extrinsic offset
		cam = '{64'd128000, 64'd128000, 64'd81920, 64'd61440, wpp_pkg::EXT_QUAT_RESET,
			64'h0000_8000, 64'hFFFF_8000, 64'h0001_0000};
		load_camera(cam);
		// directed corners: depth negative, zero, tiny, huge; quaternion extremes
		send_point(make_point(32'h0001_0000, 32'h0002_0000, 32'h0004_0000,
			16'h4000, 0, 0, 0, 0, 0, 0));
		send_point(make_point(0, 0, 32'hFFFF_0000, 16'h4000, 0, 0, 0, 0, 0, 32'h0001_0000));
		send_point(make_point(0, 0, 32'hFFFF_0000, 16'h4000, 0, 0, 0, 0, 0, 0));
		send_point(make_point(32'h0100_0000, 32'hFF00_0000, 32'hFFFF_0001,
			16'h4000, 0, 0, 0, 0, 0, 0));
		send_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			16'h4000, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_point(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			16'h4000, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_point(make_point(32'h0001_0000, 32'h0001_0000, 32'h0003_0000,
			16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0));
		send_point(make_point(32'h0001_0000, 32'h0001_0000, 32'h0003_0000,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0));
		send_point(make_point(32'h0001_0000, 32'h0001_0000, 32'h0003_0000,
			0, 0, 0, 0, 0, 0, 0));
		send_point(make_point(32'h0001_0000, 32'hFFFF_0000, 32'h0005_0000,
			0, 16'h4000, 0, 0, 0, 0, 0));
		send_point(make_point(32'h0001_0000, 32'hFFFF_0000, 32'h0005_0000,
			16'h2D41, 0, 16'h2D41, 0, 0, 0, 0));
		send_point(noise_point());
		drain();

		// extreme camera: everything at full scale, all-ones quaternion
		cam = '{64'hFF_FFFF, 64'hFF_FFFF, 64'hFF_FFFF, 64'hFF_FFFF, '1,
			64'h7FFF_FFFF, 64'h8000_0000, 64'h7FFF_FFFF};
		load_camera(cam);
		for (int i = 0; i < 10; i++) send_point(i % 2 ? noise_point() : sane_point());
		// let the pipeline back up behind a long output hold-off
		hold_req = 400;
		for (int i = 0; i < 80; i++) send_point(sane_point());
		drain();

		// random phases: new camera each time, mostly plausible geometry
		for (int ph = 0; ph < 6; ph++) begin
			cam[wpp_pkg::REG_FOCAL_X] = (ph == 5) ? 64'd0 :
				{40'd0, 24'($urandom_range(0, 24'h1F_FFFF))};
			cam[wpp_pkg::REG_FOCAL_Y] = {40'd0, 24'($urandom)};
			cam[wpp_pkg::REG_CENTER_X] = {40'd0, 24'($urandom_range(0, 24'h0F_FFFF))};
			cam[wpp_pkg::REG_CENTER_Y] = (ph == 4) ? 64'hFF_FFFF : {40'd0, 24'($urandom)};
			cam[wpp_pkg::REG_EXT_QUAT] = (ph % 2) ? {$urandom, $urandom} :
				wpp_pkg::EXT_QUAT_RESET;
			cam[wpp_pkg::REG_EXT_TX] = {32'd0,
				32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000)};
			cam[wpp_pkg::REG_EXT_TY] = {32'd0, $urandom};
			cam[wpp_pkg::REG_EXT_TZ] = {32'd0, 32'($urandom_range(0, 32'h0008_0000))};
			load_camera(cam);
			no_idle = (ph == 2);
			for (int i = 0; i < 225; i++) begin
				r = $urandom_range(0, 99);
				send_point(r < 75 ? sane_point() : noise_point());
			end
			no_idle = 0;
			drain();
		end

		$display("covered %0d points over 9 camera setups: %0d valid pixels, %0d rejected",
			words_sent, sb.n_valid, sb.n_invalid);
		$display("including depth sign, pixel and camera-frame saturation and a full stall");
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("world_point_pinhole_projection regression: pass");
		end else begin
			$display("world_point_pinhole_projection regression: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10ms;
		$display("world_point_pinhole_projection regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/wpp_pkg.sv
rtl/core/wpp_body_xform.sv
rtl/core/wpp_cam_xform.sv
rtl/core/wpp_divider.sv
rtl/core/world_point_pinhole_projection.sv
test/world_point_pinhole_projection_test.sv
